// ===== src/kle_pkg.sv =====
// Package for the keyboard line editor console: sizes, codes, item types and
// the scan code set 1 to ASCII table. No dependencies.
package kle_pkg;

    localparam int LINE_DEPTH  = 256;
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int FILL_W = $clog2(LINE_DEPTH + 1);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int COL_W  = $clog2(SCREEN_COLS);

    // Fixed port field widths.
    localparam int FUNC_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int OROW_W  = 5;
    localparam int OCOL_W  = 7;
    localparam int LEN_W   = 9;
    localparam int CFG_IDX_W = 1;
    localparam int MAX_RES = 3;
    localparam int CNT_W   = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SCAN   = 3'd0,
        FUNC_ACT    = 3'd1,
        FUNC_DEACT  = 3'd2,
        FUNC_HOME   = 3'd3,
        FUNC_READ   = 3'd4
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        KIND_CELL   = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_CURSOR = 2'd2,
        KIND_DATA   = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ECHO_COLOR  = 1'd0,
        CFG_ERASE_COLOR = 1'd1
    } t_cfg_idx;

    localparam logic [BYTE_W-1:0] ECHO_COLOR_RST  = 8'h0F;
    localparam logic [BYTE_W-1:0] ERASE_COLOR_RST = 8'hFF;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    // Request to the line store from the processing stage.
    typedef struct packed {
        logic              clear_all;
        logic              wr_set;
        logic              wr_clr;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
    } t_store_cmd;

    // One result item without the per-item status fields.
    typedef struct packed {
        t_kind             kind;
        logic [OROW_W-1:0] row;
        logic [OCOL_W-1:0] col;
        logic [BYTE_W-1:0] glyph;
        logic [BYTE_W-1:0] attr;
        logic [BYTE_W-1:0] data;
    } t_res_item;

    localparam int ROM_SIZE   = 80;
    localparam int ROM_ADDR_W = $clog2(ROM_SIZE);

    localparam logic [BYTE_W-1:0] SCAN_ROM [ROM_SIZE] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00
    };

    // Release codes and codes past the table map to no character.
    function automatic logic [BYTE_W-1:0] scan_to_ascii(input logic [BYTE_W-1:0] code);
        logic [BYTE_W-1:0] ch;
        ch = CH_NUL;
        if (int'(code) < ROM_SIZE) begin
            ch = SCAN_ROM[code[ROM_ADDR_W-1:0]];
        end
        return ch;
    endfunction

endpackage

// ===== src/kle_ifs.sv =====
// Valid/ready channel interfaces of the keyboard line editor console.
// Depends on kle_pkg for field widths.
interface kle_key_if;
    logic                          valid;
    logic                          ready;
    logic [kle_pkg::FUNC_W-1:0]    func;
    logic [kle_pkg::BYTE_W-1:0]    scancode;
    logic [kle_pkg::BYTE_W-1:0]    read_index;

    modport source (output valid, func, scancode, read_index, input ready);
    modport sink   (input valid, func, scancode, read_index, output ready);
endinterface

interface kle_res_if;
    logic                          valid;
    logic                          ready;
    logic [kle_pkg::KIND_W-1:0]    kind;
    logic [kle_pkg::OROW_W-1:0]    cell_row;
    logic [kle_pkg::OCOL_W-1:0]    cell_col;
    logic [kle_pkg::BYTE_W-1:0]    glyph;
    logic [kle_pkg::BYTE_W-1:0]    attribute;
    logic [kle_pkg::BYTE_W-1:0]    buffer_byte;
    logic [kle_pkg::LEN_W-1:0]     line_length;
    logic                          input_active;
    logic                          last;

    modport source (output valid, kind, cell_row, cell_col, glyph, attribute, buffer_byte,
                    line_length, input_active, last, input ready);
    modport sink   (input valid, kind, cell_row, cell_col, glyph, attribute, buffer_byte,
                    line_length, input_active, last, output ready);
endinterface

// ===== src/kle_line_store.sv =====
// Line buffer of the keyboard line editor: byte memory with per-entry valid
// bits and a registered read port. Depends on kle_pkg.
module kle_line_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  kle_pkg::t_store_cmd        i_cmd,
    input  logic                       i_rd_en,
    input  logic [kle_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [kle_pkg::BYTE_W-1:0] o_rd_byte
);

    logic [kle_pkg::BYTE_W-1:0]     r_mem [kle_pkg::LINE_DEPTH];
    logic [kle_pkg::LINE_DEPTH-1:0] r_vld;
    logic [kle_pkg::BYTE_W-1:0]     r_rd_data;
    logic [kle_pkg::BYTE_W-1:0]     r_fwd_data;
    logic                           r_fwd;
    logic                           r_rd_vld;

    logic                           wr_hit;
    logic                           n_rd_vld;

    // A read in the same cycle as a write to the same entry sees the new value.
    assign wr_hit = (i_cmd.wr_set || i_cmd.wr_clr) && (i_cmd.wr_addr == i_rd_addr);

    always_comb begin
        if (i_cmd.clear_all) begin
            n_rd_vld = 1'b0;
        end else if (wr_hit) begin
            n_rd_vld = i_cmd.wr_set;
        end else begin
            n_rd_vld = r_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_set) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_cmd.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_fwd    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.clear_all) begin
                r_vld <= '0;
            end else if (i_cmd.wr_set) begin
                r_vld[i_cmd.wr_addr] <= 1'b1;
            end else if (i_cmd.wr_clr) begin
                r_vld[i_cmd.wr_addr] <= 1'b0;
            end
            if (i_rd_en) begin
                r_fwd    <= wr_hit && i_cmd.wr_set && !i_cmd.clear_all;
                r_rd_vld <= n_rd_vld;
            end
        end
    end

    assign o_rd_byte = !r_rd_vld ? '0 : (r_fwd ? r_fwd_data : r_rd_data);

endmodule

// ===== src/keyboard_line_editor_console.sv =====
// Top level of the keyboard line editor console: input stage, editor and
// cursor logic, result buffer. Depends on kle_pkg, kle_ifs and kle_line_store.
//
//  Channel   Direction  Handshake        Carries
//  i_key     in         valid / ready    func, scancode, read_index
//  o_res     out        valid / ready    one result item: kind .. last
//  i_cfg_*   in         write enable     echo_color (0), erase_color (1)
//
// An accepted item is registered in the input stage, which turns it into up to
// three result items in one pass; they leave one per cycle while o_res.ready is
// high. Unused function codes give no result; control items, reads, enter off
// the bottom row and keys that change nothing give one; an echoed or erased key
// or an enter that scrolls gives two; an echo in the bottom right cell, three.
// A stalled output holds one group in the buffer and one item in the input stage.
// Reset is synchronous; the line buffer is cleared at once through its valid bits.
module keyboard_line_editor_console (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    kle_key_if.sink                       i_key,
    kle_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [kle_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kle_pkg::BYTE_W-1:0]    i_cfg_data
);

    // Configuration registers.
    logic [kle_pkg::BYTE_W-1:0] r_echo_color;
    logic [kle_pkg::BYTE_W-1:0] r_erase_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_color  <= kle_pkg::ECHO_COLOR_RST;
            r_erase_color <= kle_pkg::ERASE_COLOR_RST;
        end else if (i_cfg_we) begin
            unique case (kle_pkg::t_cfg_idx'(i_cfg_idx))
                kle_pkg::CFG_ECHO_COLOR:  r_echo_color  <= i_cfg_data;
                kle_pkg::CFG_ERASE_COLOR: r_erase_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Editor state.
    logic [kle_pkg::FILL_W-1:0] r_fill, n_fill;
    logic                       r_acc, n_acc;
    logic [kle_pkg::ROW_W-1:0]  r_row, n_row;
    logic [kle_pkg::COL_W-1:0]  r_col, n_col;

    // Input stage.
    logic                       r_stg_v;
    kle_pkg::t_func             r_stg_func;
    logic [kle_pkg::BYTE_W-1:0] r_stg_code;
    logic                       r_stg_inrng;

    // Result buffer: the items of one input item and a read position.
    kle_pkg::t_res_item         r_res [kle_pkg::MAX_RES];
    logic [kle_pkg::CNT_W-1:0]  r_left;
    logic [kle_pkg::CNT_W-1:0]  r_pos;
    logic [kle_pkg::FILL_W-1:0] r_len;
    logic                       r_act;

    kle_pkg::t_res_item         res [kle_pkg::MAX_RES];
    logic [kle_pkg::CNT_W-1:0]  res_cnt;
    kle_pkg::t_store_cmd        store_cmd;
    logic [kle_pkg::BYTE_W-1:0] store_byte;
    logic [kle_pkg::BYTE_W-1:0] ch;

    logic key_fire;
    logic out_fire;
    logic buf_free;
    logic stg_move;

    // The buffer takes a new group once its last item leaves, in the same cycle.
    assign out_fire = o_res.valid && o_res.ready;
    assign buf_free = (r_left == '0) || ((r_left == kle_pkg::CNT_W'(1)) && o_res.ready);
    assign stg_move = r_stg_v && buf_free;
    assign i_key.ready = !r_stg_v || stg_move;
    assign key_fire = i_key.valid && i_key.ready;

    always_ff @(posedge i_clk) begin
        if (key_fire) begin
            r_stg_func  <= kle_pkg::t_func'(i_key.func);
            r_stg_code  <= i_key.scancode;
            r_stg_inrng <= int'(i_key.read_index) < kle_pkg::LINE_DEPTH;
        end
    end

    // The store is read as the item enters the input stage; its data is
    // ready when the item is processed. A write from the item ahead of it
    // in the same cycle is forwarded inside the store.
    kle_line_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (store_cmd),
        .i_rd_en   (key_fire),
        .i_rd_addr (kle_pkg::ADDR_W'(i_key.read_index)),
        .o_rd_byte (store_byte)
    );

    assign ch = kle_pkg::scan_to_ascii(r_stg_code);

    // Single pass over the item in the input stage. Results are appended
    // in order at slot res_cnt; state moves to its value after the item.
    always_comb begin
        n_fill  = r_fill;
        n_acc   = r_acc;
        n_row   = r_row;
        n_col   = r_col;
        res_cnt = '0;
        for (int i = 0; i < kle_pkg::MAX_RES; i++) begin
            res[i] = '0;
        end
        store_cmd = '0;
        store_cmd.wr_data = ch;

        unique case (r_stg_func)
            kle_pkg::FUNC_SCAN: begin
                if (!r_acc) begin
                    n_fill = '0;
                end else if (ch == kle_pkg::CH_BS) begin
                    if (r_fill != '0) begin
                        n_fill = r_fill - 1'b1;
                        store_cmd.wr_clr  = 1'b1;
                        store_cmd.wr_addr = kle_pkg::ADDR_W'(n_fill);
                        // Step back one cell, across a row boundary if needed;
                        // the top left corner stays put.
                        if (r_col == '0) begin
                            if (r_row != '0) begin
                                n_row = r_row - 1'b1;
                                n_col = kle_pkg::COL_W'(kle_pkg::SCREEN_COLS - 1);
                            end
                        end else begin
                            n_col = r_col - 1'b1;
                        end
                        res[res_cnt].kind  = kle_pkg::KIND_CELL;
                        res[res_cnt].row   = kle_pkg::OROW_W'(n_row);
                        res[res_cnt].col   = kle_pkg::OCOL_W'(n_col);
                        res[res_cnt].glyph = kle_pkg::CH_SPACE;
                        res[res_cnt].attr  = r_erase_color;
                        res_cnt = res_cnt + 1'b1;
                    end
                end else if (ch == kle_pkg::CH_LF) begin
                    // Enter: new line, empty index, input ends.
                    n_fill = '0;
                    n_acc  = 1'b0;
                    n_col  = '0;
                    if (r_row == kle_pkg::ROW_W'(kle_pkg::SCREEN_ROWS - 1)) begin
                        res[res_cnt].kind  = kle_pkg::KIND_SCROLL;
                        res[res_cnt].row   = kle_pkg::OROW_W'(kle_pkg::SCREEN_ROWS - 1);
                        res[res_cnt].glyph = kle_pkg::CH_SPACE;
                        res[res_cnt].attr  = r_erase_color;
                        res_cnt = res_cnt + 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else if (ch != kle_pkg::CH_TAB && ch != kle_pkg::CH_NUL) begin
                    // Printable key; a full buffer drops it silently.
                    if (int'(r_fill) < kle_pkg::LINE_DEPTH) begin
                        n_fill = r_fill + 1'b1;
                        store_cmd.wr_set  = 1'b1;
                        store_cmd.wr_addr = kle_pkg::ADDR_W'(r_fill);
                        res[res_cnt].kind  = kle_pkg::KIND_CELL;
                        res[res_cnt].row   = kle_pkg::OROW_W'(r_row);
                        res[res_cnt].col   = kle_pkg::OCOL_W'(r_col);
                        res[res_cnt].glyph = ch;
                        res[res_cnt].attr  = r_echo_color;
                        res_cnt = res_cnt + 1'b1;
                        if (r_col == kle_pkg::COL_W'(kle_pkg::SCREEN_COLS - 1)) begin
                            // Wrap to the next row, scrolling at the bottom.
                            n_col = '0;
                            if (r_row == kle_pkg::ROW_W'(kle_pkg::SCREEN_ROWS - 1)) begin
                                res[res_cnt].kind  = kle_pkg::KIND_SCROLL;
                                res[res_cnt].row   =
                                    kle_pkg::OROW_W'(kle_pkg::SCREEN_ROWS - 1);
                                res[res_cnt].glyph = kle_pkg::CH_SPACE;
                                res[res_cnt].attr  = r_erase_color;
                                res_cnt = res_cnt + 1'b1;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                end
                res[res_cnt].kind = kle_pkg::KIND_CURSOR;
                res[res_cnt].row  = kle_pkg::OROW_W'(n_row);
                res[res_cnt].col  = kle_pkg::OCOL_W'(n_col);
                res_cnt = res_cnt + 1'b1;
            end
            kle_pkg::FUNC_ACT: begin
                store_cmd.clear_all = 1'b1;
                n_acc  = 1'b1;
                n_fill = '0;
                res[0].kind = kle_pkg::KIND_CURSOR;
                res[0].row  = kle_pkg::OROW_W'(r_row);
                res[0].col  = kle_pkg::OCOL_W'(r_col);
                res_cnt = kle_pkg::CNT_W'(1);
            end
            kle_pkg::FUNC_DEACT: begin
                n_acc = 1'b0;
                res[0].kind = kle_pkg::KIND_CURSOR;
                res[0].row  = kle_pkg::OROW_W'(r_row);
                res[0].col  = kle_pkg::OCOL_W'(r_col);
                res_cnt = kle_pkg::CNT_W'(1);
            end
            kle_pkg::FUNC_HOME: begin
                n_row = '0;
                n_col = '0;
                res[0].kind = kle_pkg::KIND_CURSOR;
                res_cnt = kle_pkg::CNT_W'(1);
            end
            kle_pkg::FUNC_READ: begin
                res[0].kind = kle_pkg::KIND_DATA;
                res[0].data = r_stg_inrng ? store_byte : '0;
                res_cnt = kle_pkg::CNT_W'(1);
            end
            default: ;
        endcase

        // Nothing changes unless the item actually leaves the input stage.
        if (!stg_move) begin
            store_cmd.clear_all = 1'b0;
            store_cmd.wr_set    = 1'b0;
            store_cmd.wr_clr    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_v <= 1'b0;
            r_fill  <= '0;
            r_acc   <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_left  <= '0;
            r_pos   <= '0;
        end else begin
            if (i_key.ready) begin
                r_stg_v <= i_key.valid;
            end
            if (stg_move) begin
                r_fill <= n_fill;
                r_acc  <= n_acc;
                r_row  <= n_row;
                r_col  <= n_col;
                r_left <= res_cnt;
                r_pos  <= '0;
            end else if (out_fire) begin
                r_left <= r_left - 1'b1;
                r_pos  <= r_pos + 1'b1;
            end
        end
    end

    // Result payload and the status that every item of the group carries.
    always_ff @(posedge i_clk) begin
        if (stg_move) begin
            r_res <= res;
            r_len <= n_fill;
            r_act <= n_acc;
        end
    end

    assign o_res.valid        = (r_left != '0);
    assign o_res.kind         = r_res[r_pos].kind;
    assign o_res.cell_row     = r_res[r_pos].row;
    assign o_res.cell_col     = r_res[r_pos].col;
    assign o_res.glyph        = r_res[r_pos].glyph;
    assign o_res.attribute    = r_res[r_pos].attr;
    assign o_res.buffer_byte  = r_res[r_pos].data;
    assign o_res.line_length  = kle_pkg::LEN_W'(r_len);
    assign o_res.input_active = r_act;
    assign o_res.last         = (r_left == kle_pkg::CNT_W'(1));

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for keyboard_line_editor_console: drives key items,
// predicts the console results and checks them. Depends on kle_pkg, kle_ifs and the RTL.
`timescale 1ns / 1ps

module tb;
    import kle_pkg::*;

    // Run control.
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int GAP_MAX      = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 40;

    // Function codes beyond the defined ones are ignored by the block.
    localparam int FUNC_FIRST_UNUSED = int'(FUNC_READ) + 1;
    localparam int FUNC_LAST_CODE    = (1 << FUNC_W) - 1;

    // Scan codes used by name in the stimulus.
    localparam logic [BYTE_W-1:0] SC_NONE      = 8'h00;
    localparam logic [BYTE_W-1:0] SC_ESC       = 8'h01;
    localparam logic [BYTE_W-1:0] SC_BKSP      = 8'h0E;
    localparam logic [BYTE_W-1:0] SC_TAB       = 8'h0F;
    localparam logic [BYTE_W-1:0] SC_Q         = 8'h10;
    localparam logic [BYTE_W-1:0] SC_ENTER     = 8'h1C;
    localparam logic [BYTE_W-1:0] SC_A         = 8'h1E;
    localparam logic [BYTE_W-1:0] SC_SPACE     = 8'h39;
    localparam logic [BYTE_W-1:0] SC_KP_PLUS   = 8'h4E;
    localparam logic [BYTE_W-1:0] SC_PAST_MAP  = 8'h55;
    localparam logic [BYTE_W-1:0] SC_RELEASE_A = 8'h9E;
    localparam logic [BYTE_W-1:0] SC_MAX       = 8'hFF;
    localparam int                RELEASE_FIRST = 128;

    // Scan code set 1 to ASCII, make codes only; zero means no character.
    localparam int KEYMAP_SIZE = 80;
    localparam logic [BYTE_W-1:0] KEYMAP [KEYMAP_SIZE] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00
    };

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] ridx;
    } t_key_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OROW_W-1:0] row;
        logic [OCOL_W-1:0] col;
        logic [BYTE_W-1:0] glyph;
        logic [BYTE_W-1:0] attr;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              active;
        logic              last;
    } t_console_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BYTE_W-1:0]    i_cfg_data;

    kle_key_if key_ch ();
    kle_res_if res_ch ();

    keyboard_line_editor_console uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (key_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predicted console state: line buffer, fill index, input flag, cursor
    // and the two color registers.
    logic [BYTE_W-1:0] line_mem [LINE_DEPTH];
    int unsigned       fill_cnt;
    bit                accepting;
    int unsigned       crow;
    int unsigned       ccol;
    logic [BYTE_W-1:0] echo_attr;
    logic [BYTE_W-1:0] erase_attr;

    t_console_res staged_results[$];
    t_console_res expected_results[$];
    t_key_item    pending_keys[$];

    // Bookkeeping.
    int unsigned n_fail;
    int unsigned items_accepted;
    int unsigned results_seen;
    int unsigned random_items;
    bit          counting_random;
    int unsigned cfg_writes;
    int unsigned n_scrolls;
    int unsigned n_dropped;
    int unsigned n_triple;
    int unsigned cycle_count;

    // Idle shaping, set per phase by the sequencer.
    int unsigned key_gap_max;
    int unsigned res_stall_max;
    int unsigned key_gap;
    int unsigned res_stall;
    int unsigned stall_draw;
    t_key_item   drv_item;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Queue one result of the current item; the per-item status fields are
    // filled in once the whole item has been worked out.
    function automatic void stage_result(logic [KIND_W-1:0] kind, int unsigned row,
                                         int unsigned col, logic [BYTE_W-1:0] glyph,
                                         logic [BYTE_W-1:0] attr, logic [BYTE_W-1:0] data);
        t_console_res r;
        r       = '0;
        r.kind  = kind;
        r.row   = OROW_W'(row);
        r.col   = OCOL_W'(col);
        r.glyph = glyph;
        r.attr  = attr;
        r.data  = data;
        staged_results.push_back(r);
    endfunction

    // Move to column 0 of the next row. Past the bottom row the screen
    // scrolls up and the cursor stays on the bottom row.
    function automatic void advance_line();
        ccol = 0;
        crow++;
        if (crow >= SCREEN_ROWS) begin
            crow = SCREEN_ROWS - 1;
            stage_result(KIND_SCROLL, SCREEN_ROWS - 1, 0, CH_SPACE, erase_attr, CH_NUL);
            n_scrolls++;
        end
    endfunction

    function automatic void apply_key(logic [BYTE_W-1:0] ch);
        if (ch == CH_BS) begin
            // An empty line ignores backspace. At the top left corner the
            // cursor cannot move back, but the cell is still blanked.
            if (fill_cnt > 0) begin
                fill_cnt--;
                line_mem[fill_cnt] = CH_NUL;
                if (ccol == 0) begin
                    if (crow != 0) begin
                        crow--;
                        ccol = SCREEN_COLS - 1;
                    end
                end else begin
                    ccol--;
                end
                stage_result(KIND_CELL, crow, ccol, CH_SPACE, erase_attr, CH_NUL);
            end
        end else if (ch == CH_LF) begin
            fill_cnt = 0;
            advance_line();
            accepting = 1'b0;
        end else if (ch != CH_TAB) begin
            // A full line buffer drops the key without an echo.
            if (fill_cnt < LINE_DEPTH) begin
                line_mem[fill_cnt] = ch;
                fill_cnt++;
                stage_result(KIND_CELL, crow, ccol, ch, echo_attr, CH_NUL);
                if (ccol >= SCREEN_COLS - 1) begin
                    advance_line();
                end else begin
                    ccol++;
                end
            end else begin
                n_dropped++;
            end
        end
    endfunction

    function automatic void predict_console(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] code,
                                            logic [BYTE_W-1:0] ridx);
        logic [BYTE_W-1:0] ch;
        t_console_res      r;
        staged_results.delete();
        case (f)
            FUNC_SCAN: begin
                if (!accepting) begin
                    fill_cnt = 0;
                end else begin
                    ch = (int'(code) < KEYMAP_SIZE) ? KEYMAP[code[6:0]] : CH_NUL;
                    if (ch != CH_NUL) begin
                        apply_key(ch);
                    end
                end
                stage_result(KIND_CURSOR, crow, ccol, CH_NUL, CH_NUL, CH_NUL);
            end
            FUNC_ACT: begin
                foreach (line_mem[i]) line_mem[i] = CH_NUL;
                accepting = 1'b1;
                fill_cnt  = 0;
                stage_result(KIND_CURSOR, crow, ccol, CH_NUL, CH_NUL, CH_NUL);
            end
            FUNC_DEACT: begin
                accepting = 1'b0;
                stage_result(KIND_CURSOR, crow, ccol, CH_NUL, CH_NUL, CH_NUL);
            end
            FUNC_HOME: begin
                crow = 0;
                ccol = 0;
                stage_result(KIND_CURSOR, crow, ccol, CH_NUL, CH_NUL, CH_NUL);
            end
            FUNC_READ: begin
                stage_result(KIND_DATA, 0, 0, CH_NUL, CH_NUL,
                             (int'(ridx) < LINE_DEPTH) ? line_mem[ridx] : CH_NUL);
            end
            default: begin
            end
        endcase
        if (staged_results.size() == MAX_RES) begin
            n_triple++;
        end
        foreach (staged_results[k]) begin
            r        = staged_results[k];
            r.len    = LEN_W'(fill_cnt);
            r.active = accepting;
            r.last   = (k == staged_results.size() - 1);
            expected_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        if (n_fail < MAX_REPORTS) begin
            $display("[%0t] ERROR result %0d: %s", $time, results_seen, msg);
        end
        n_fail++;
    endtask

    task automatic compare_field(string name, logic [LEN_W-1:0] got, logic [LEN_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    task automatic check_result();
        t_console_res want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("arrived with nothing expected, kind %0d", res_ch.kind));
        end else begin
            want = expected_results.pop_front();
            compare_field("kind", LEN_W'(res_ch.kind), LEN_W'(want.kind));
            compare_field("cell_row", LEN_W'(res_ch.cell_row), LEN_W'(want.row));
            compare_field("cell_col", LEN_W'(res_ch.cell_col), LEN_W'(want.col));
            compare_field("glyph", LEN_W'(res_ch.glyph), LEN_W'(want.glyph));
            compare_field("attribute", LEN_W'(res_ch.attribute), LEN_W'(want.attr));
            compare_field("buffer_byte", LEN_W'(res_ch.buffer_byte), LEN_W'(want.data));
            compare_field("line_length", res_ch.line_length, want.len);
            compare_field("input_active", LEN_W'(res_ch.input_active), LEN_W'(want.active));
            compare_field("last", LEN_W'(res_ch.last), LEN_W'(want.last));
        end
        results_seen++;
    endtask

    // ------------------------------------------------------------------
    // Driver: presents the pending key items one at a time. The prediction
    // runs at the edge where an item is accepted, and after each item a
    // random number of idle cycles is drawn before the next one is shown.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_ch.valid <= 1'b0;
            key_gap      <= 0;
        end else begin
            if (key_ch.valid && key_ch.ready) begin
                predict_console(key_ch.func, key_ch.scancode, key_ch.read_index);
                items_accepted++;
            end
            if (!key_ch.valid || key_ch.ready) begin
                if (key_gap > 0) begin
                    key_gap      <= key_gap - 1;
                    key_ch.valid <= 1'b0;
                end else if (pending_keys.size() > 0) begin
                    drv_item          = pending_keys.pop_front();
                    key_ch.valid      <= 1'b1;
                    key_ch.func       <= drv_item.func;
                    key_ch.scancode   <= drv_item.code;
                    key_ch.read_index <= drv_item.ridx;
                    key_gap           <= $urandom_range(0, key_gap_max);
                end else begin
                    key_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every accepted result, then holds ready low for a
    // random number of cycles so that stalls hit every result position.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            res_stall    <= 0;
        end else if (res_ch.valid && res_ch.ready) begin
            check_result();
            stall_draw = $urandom_range(0, res_stall_max);
            res_stall    <= stall_draw;
            res_ch.ready <= (stall_draw == 0);
        end else if (res_stall > 0) begin
            res_stall    <= res_stall - 1;
            res_ch.ready <= (res_stall == 1);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("keyboard_line_editor_console: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void push_key(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] code,
                                     logic [BYTE_W-1:0] ridx);
        t_key_item k;
        k.func = f;
        k.code = code;
        k.ridx = ridx;
        pending_keys.push_back(k);
        if (counting_random && f <= FUNC_READ) begin
            random_items++;
        end
    endfunction

    // Fields that an item does not use still get random values.
    function automatic void push_scan(logic [BYTE_W-1:0] code);
        push_key(FUNC_SCAN, code, 8'($urandom));
    endfunction

    function automatic void push_ctrl(logic [FUNC_W-1:0] f);
        push_key(f, 8'($urandom), 8'($urandom));
    endfunction

    function automatic void push_read(logic [BYTE_W-1:0] idx);
        push_key(FUNC_READ, 8'($urandom), idx);
    endfunction

    // A key that lands in the line buffer: mapped, and not backspace,
    // tab or enter.
    function automatic logic [BYTE_W-1:0] pick_printable();
        logic [BYTE_W-1:0] c;
        c = 8'($urandom_range(0, KEYMAP_SIZE - 1));
        while (KEYMAP[c[6:0]] == CH_NUL || KEYMAP[c[6:0]] == CH_BS ||
               KEYMAP[c[6:0]] == CH_TAB || KEYMAP[c[6:0]] == CH_LF) begin
            c = 8'($urandom_range(0, KEYMAP_SIZE - 1));
        end
        return c;
    endfunction

    // A code that maps to no character: a release, a code past the table,
    // or a hole inside it.
    function automatic logic [BYTE_W-1:0] pick_dead_code();
        logic [BYTE_W-1:0] c;
        case ($urandom_range(0, 2))
            0: c = 8'($urandom_range(RELEASE_FIRST, 255));
            1: c = 8'($urandom_range(KEYMAP_SIZE, RELEASE_FIRST - 1));
            default: begin
                c = 8'($urandom_range(0, KEYMAP_SIZE - 1));
                while (KEYMAP[c[6:0]] != CH_NUL) begin
                    c = 8'($urandom_range(0, KEYMAP_SIZE - 1));
                end
            end
        endcase
        return c;
    endfunction

    // An empty line: enable input and press enter at once.
    function automatic void gen_blank_line();
        push_ctrl(FUNC_ACT);
        push_scan(SC_ENTER);
    endfunction

    // One random sequence. Most are well-formed lines typed after an
    // activate; the rest are reads, homes and plain noise.
    task automatic gen_sequence();
        int unsigned sel;
        int unsigned n;
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            push_ctrl(FUNC_ACT);
            n = $urandom_range(0, 8);
            repeat (n) begin
                sel = $urandom_range(0, 19);
                if (sel < 13) begin
                    push_scan(pick_printable());
                end else if (sel < 16) begin
                    push_scan(SC_BKSP);
                end else if (sel < 17) begin
                    push_scan(SC_TAB);
                end else if (sel < 19) begin
                    push_scan(pick_dead_code());
                end else begin
                    push_read(8'($urandom_range(0, 15)));
                end
            end
            sel = $urandom_range(0, 9);
            if (sel < 8) begin
                push_scan(SC_ENTER);
            end else if (sel < 9) begin
                push_ctrl(FUNC_DEACT);
            end
        end else if (sel < 65) begin
            repeat ($urandom_range(1, 3)) gen_blank_line();
        end else if (sel < 80) begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 3) == 0) begin
                    push_read(8'($urandom));
                end else begin
                    push_read(8'($urandom_range(0, 15)));
                end
            end
        end else if (sel < 93) begin
            repeat ($urandom_range(1, 3)) begin
                push_key(FUNC_W'($urandom_range(0, FUNC_LAST_CODE)), 8'($urandom),
                         8'($urandom));
            end
        end else if (sel < 96) begin
            push_ctrl(FUNC_HOME);
        end else begin
            // Keys typed after input was switched off.
            push_ctrl(FUNC_DEACT);
            push_scan($urandom_range(0, 1) ? pick_printable() : pick_dead_code());
        end
    endtask

    task automatic run_random(int unsigned budget);
        int unsigned target;
        target = random_items + budget;
        while (random_items < target) begin
            gen_sequence();
        end
    endtask

    // Wait until every item is in and every expected result has come out,
    // then let the block run on idle so that items without results finish too.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_keys.size() != 0 || key_ch.valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Register writes happen only while the block is idle, so the predictor
    // can take the new value as soon as the write is done.
    task automatic cfg_write(t_cfg_idx idx, logic [BYTE_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_ECHO_COLOR:  echo_attr  = value;
            CFG_ERASE_COLOR: erase_attr = value;
            default: begin
            end
        endcase
        cfg_writes++;
    endtask

    task automatic set_idling(int unsigned key_max, int unsigned res_max);
        key_gap_max   = key_max;
        res_stall_max = res_max;
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_ECHO_COLOR;
        i_cfg_data        = '0;
        key_ch.valid      = 1'b0;
        key_ch.func       = FUNC_SCAN;
        key_ch.scancode   = '0;
        key_ch.read_index = '0;
        res_ch.ready      = 1'b0;
        foreach (line_mem[i]) line_mem[i] = CH_NUL;
        fill_cnt        = 0;
        accepting       = 1'b0;
        crow            = 0;
        ccol            = 0;
        echo_attr       = ECHO_COLOR_RST;
        erase_attr      = ERASE_COLOR_RST;
        n_fail          = 0;
        items_accepted  = 0;
        results_seen    = 0;
        random_items    = 0;
        counting_random = 1'b0;
        cfg_writes      = 0;
        n_scrolls       = 0;
        n_dropped       = 0;
        n_triple        = 0;
        cycle_count     = 0;
        key_gap_max     = GAP_MAX;
        res_stall_max   = GAP_MAX;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the colors at their reset values. It walks the
        // corner cases: keys while input is off, unknown functions, release
        // and unmapped codes, tab, escape stored as a character, backspace
        // at the top left corner and on an empty line, and enter.
        @(negedge i_clk);
        push_scan(SC_A);
        push_read(8'h00);
        push_ctrl(FUNC_W'(FUNC_FIRST_UNUSED));
        push_ctrl(FUNC_W'(FUNC_LAST_CODE));
        push_ctrl(FUNC_ACT);
        push_scan(SC_A);
        push_scan(SC_RELEASE_A);
        push_scan(SC_NONE);
        push_scan(SC_PAST_MAP);
        push_scan(SC_TAB);
        push_scan(SC_ESC);
        push_scan(SC_KP_PLUS);
        push_read(8'h01);
        push_read(8'(LINE_DEPTH - 1));
        push_ctrl(FUNC_HOME);
        push_scan(SC_BKSP);
        push_scan(SC_BKSP);
        push_scan(SC_BKSP);
        push_scan(SC_BKSP);
        push_scan(SC_SPACE);
        push_ctrl(FUNC_DEACT);
        push_scan(SC_Q);
        push_ctrl(FUNC_ACT);
        push_scan(SC_Q);
        push_scan(SC_ENTER);
        push_scan(SC_MAX);
        wait_idle();

        counting_random = 1'b1;

        // Extreme colors, then blank lines to bring the cursor down to the
        // bottom rows, followed by one long line. The long line wraps the
        // cursor, backs up across a row boundary, fills the buffer to its
        // depth and keeps typing so that keys get dropped. On the bottom row
        // each wrap also scrolls the screen.
        cfg_write(CFG_ECHO_COLOR, 8'hFF);
        cfg_write(CFG_ERASE_COLOR, 8'h00);
        set_idling(GAP_MAX, GAP_MAX);
        @(negedge i_clk);
        repeat (SCREEN_ROWS - 3) gen_blank_line();
        push_ctrl(FUNC_ACT);
        repeat (SCREEN_COLS) push_scan(pick_printable());
        repeat (2) push_scan(SC_BKSP);
        repeat (LINE_DEPTH - SCREEN_COLS + 8) push_scan(pick_printable());
        push_read(8'(LINE_DEPTH - 1));
        repeat (3) push_read(8'($urandom_range(LINE_DEPTH - 16, LINE_DEPTH - 1)));
        push_scan(SC_BKSP);
        push_scan(pick_printable());
        push_scan(pick_printable());
        push_read(8'(LINE_DEPTH - 1));
        push_scan(SC_ENTER);
        wait_idle();

        // The opposite extremes, with no idling on either side.
        cfg_write(CFG_ECHO_COLOR, 8'h00);
        cfg_write(CFG_ERASE_COLOR, 8'hFF);
        set_idling(0, 0);
        @(negedge i_clk);
        run_random(25);
        wait_idle();

        // Random colors; only the sender idles.
        cfg_write(CFG_ECHO_COLOR, 8'($urandom));
        cfg_write(CFG_ERASE_COLOR, 8'($urandom));
        set_idling(GAP_MAX, 0);
        @(negedge i_clk);
        run_random(25);
        wait_idle();

        // Random colors; only the receiver stalls.
        cfg_write(CFG_ERASE_COLOR, 8'($urandom));
        cfg_write(CFG_ECHO_COLOR, 8'($urandom));
        set_idling(0, GAP_MAX);
        @(negedge i_clk);
        run_random(25);
        wait_idle();

        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        end

        $display("Sent %0d key items through %0d register writes; checked %0d results.",
                 items_accepted, cfg_writes, results_seen);
        $display("Saw %0d scrolls, %0d keys dropped on a full line, %0d three-result items.",
                 n_scrolls, n_dropped, n_triple);
        if (n_fail == 0) begin
            $display("keyboard_line_editor_console: match");
        end else begin
            $display("keyboard_line_editor_console: mismatch");
        end
        $finish;
    end

endmodule
